// ----- rtl/core/rbst_pkg.sv -----
package rbst_pkg;

    localparam int NUM_AXES     = 3;
    localparam int CFG_IDX_BITS = 3;

    // configuration register map
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_ORIGIN_X  = 3'd0,
        REG_ORIGIN_Y  = 3'd1,
        REG_ORIGIN_Z  = 3'd2,
        REG_INV_DIR_X = 3'd3,
        REG_INV_DIR_Y = 3'd4,
        REG_INV_DIR_Z = 3'd5,
        REG_CLIP_DIST = 3'd6
    } cfg_reg_t;

endpackage

// ----- rtl/core/rbst_axis_cell.sv -----
module rbst_axis_cell
    import rbst_pkg::*;
#(
    parameter int W    = 32,
    parameter int F    = 16,
    parameter int AXIS = 0
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [W-1:0]                     org,
    input  logic [W-1:0]                     inv,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [NUM_AXES-1:0][W-1:0]       in_box_min,
    input  logic [NUM_AXES-1:0][W-1:0]       in_box_max,
    input  logic [W-1:0]                     in_tmin,
    input  logic [W-1:0]                     in_tmax,
    input  logic                             in_miss,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [NUM_AXES-1:0][W-1:0]       out_box_min,
    output logic [NUM_AXES-1:0][W-1:0]       out_box_max,
    output logic [W-1:0]                     out_tmin,
    output logic [W-1:0]                     out_tmax,
    output logic                             out_miss
);

    localparam int PW = 2 * W + 1;

    // stage valids: a = magnitudes, b = products, c = scaled, d = interval
    logic a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg;
    logic a_ready, b_ready, c_ready, d_ready;

    assign d_ready  = !d_valid_reg || out_ready;
    assign c_ready  = !c_valid_reg || d_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    // carried payload per stage
    logic [NUM_AXES-1:0][W-1:0] a_bmin_reg, a_bmax_reg, b_bmin_reg, b_bmax_reg;
    logic [NUM_AXES-1:0][W-1:0] c_bmin_reg, c_bmax_reg, d_bmin_reg, d_bmax_reg;
    logic [W-1:0] a_tmin_reg, a_tmax_reg, b_tmin_reg, b_tmax_reg, c_tmin_reg, c_tmax_reg;
    logic [W-1:0] d_tmin_reg, d_tmax_reg;
    logic         a_miss_reg, b_miss_reg, c_miss_reg, d_miss_reg;

    // stage a: differences and sign-magnitude split
    logic signed [W:0] dn, df;
    logic [W:0]        mag_dn_next, mag_df_next;
    logic [W-1:0]      mag_inv_next;
    logic              neg_n_next, neg_f_next;
    logic [W:0]        a_mag_dn_reg, a_mag_df_reg;
    logic [W-1:0]      a_mag_inv_reg;
    logic              a_neg_n_reg, a_neg_f_reg;

    always_comb begin
        dn = $signed({in_box_min[AXIS][W-1], in_box_min[AXIS]})
           - $signed({org[W-1], org});
        df = $signed({in_box_max[AXIS][W-1], in_box_max[AXIS]})
           - $signed({org[W-1], org});
        mag_dn_next  = dn[W] ? (~dn + 1'b1) : dn;
        mag_df_next  = df[W] ? (~df + 1'b1) : df;
        mag_inv_next = inv[W-1] ? (~inv + 1'b1) : inv;
        neg_n_next   = dn[W] ^ inv[W-1];
        neg_f_next   = df[W] ^ inv[W-1];
    end

    // stage b: full products
    logic [PW-1:0] prod_n_next, prod_f_next;
    logic [PW-1:0] b_prod_n_reg, b_prod_f_reg;
    logic          b_neg_n_reg, b_neg_f_reg;

    assign prod_n_next = PW'(a_mag_dn_reg) * PW'(a_mag_inv_reg);
    assign prod_f_next = PW'(a_mag_df_reg) * PW'(a_mag_inv_reg);

    // stage c: drop fraction, saturate, restore sign
    logic [PW-1:0] q_n, q_f, lim_n, lim_f, sat_n, sat_f;
    logic [W-1:0]  tn_next, tf_next;
    logic [W-1:0]  c_tn_reg, c_tf_reg;

    always_comb begin
        q_n   = b_prod_n_reg >> F;
        q_f   = b_prod_f_reg >> F;
        lim_n = ((PW'(1) << (W - 1)) - PW'(1)) + PW'(b_neg_n_reg);
        lim_f = ((PW'(1) << (W - 1)) - PW'(1)) + PW'(b_neg_f_reg);
        sat_n = (q_n > lim_n) ? lim_n : q_n;
        sat_f = (q_f > lim_f) ? lim_f : q_f;
        tn_next = b_neg_n_reg ? (~sat_n[W-1:0] + 1'b1) : sat_n[W-1:0];
        tf_next = b_neg_f_reg ? (~sat_f[W-1:0] + 1'b1) : sat_f[W-1:0];
    end

    // stage d: order near/far and narrow the interval
    logic [W-1:0] near_v, far_v, tmin_next, tmax_next;
    logic         miss_next;

    always_comb begin
        if ($signed(c_tn_reg) > $signed(c_tf_reg)) begin
            near_v = c_tf_reg;
            far_v  = c_tn_reg;
        end else begin
            near_v = c_tn_reg;
            far_v  = c_tf_reg;
        end
        tmin_next = ($signed(near_v) > $signed(c_tmin_reg)) ? near_v : c_tmin_reg;
        tmax_next = ($signed(far_v) < $signed(c_tmax_reg)) ? far_v : c_tmax_reg;
        miss_next = c_miss_reg || ($signed(tmin_next) > $signed(tmax_next));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end else begin
            if (a_ready) begin
                a_valid_reg <= in_valid;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready) begin
                c_valid_reg <= b_valid_reg;
            end
            if (d_ready) begin
                d_valid_reg <= c_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready && in_valid) begin
            a_bmin_reg    <= in_box_min;
            a_bmax_reg    <= in_box_max;
            a_tmin_reg    <= in_tmin;
            a_tmax_reg    <= in_tmax;
            a_miss_reg    <= in_miss;
            a_mag_dn_reg  <= mag_dn_next;
            a_mag_df_reg  <= mag_df_next;
            a_mag_inv_reg <= mag_inv_next;
            a_neg_n_reg   <= neg_n_next;
            a_neg_f_reg   <= neg_f_next;
        end
        if (b_ready && a_valid_reg) begin
            b_bmin_reg   <= a_bmin_reg;
            b_bmax_reg   <= a_bmax_reg;
            b_tmin_reg   <= a_tmin_reg;
            b_tmax_reg   <= a_tmax_reg;
            b_miss_reg   <= a_miss_reg;
            b_prod_n_reg <= prod_n_next;
            b_prod_f_reg <= prod_f_next;
            b_neg_n_reg  <= a_neg_n_reg;
            b_neg_f_reg  <= a_neg_f_reg;
        end
        if (c_ready && b_valid_reg) begin
            c_bmin_reg <= b_bmin_reg;
            c_bmax_reg <= b_bmax_reg;
            c_tmin_reg <= b_tmin_reg;
            c_tmax_reg <= b_tmax_reg;
            c_miss_reg <= b_miss_reg;
            c_tn_reg   <= tn_next;
            c_tf_reg   <= tf_next;
        end
        if (d_ready && c_valid_reg) begin
            d_bmin_reg <= c_bmin_reg;
            d_bmax_reg <= c_bmax_reg;
            d_tmin_reg <= tmin_next;
            d_tmax_reg <= tmax_next;
            d_miss_reg <= miss_next;
        end
    end

    assign out_valid   = d_valid_reg;
    assign out_box_min = d_bmin_reg;
    assign out_box_max = d_bmax_reg;
    assign out_tmin    = d_tmin_reg;
    assign out_tmax    = d_tmax_reg;
    assign out_miss    = d_miss_reg;

endmodule

// ----- rtl/core/ray_box_slab_test.sv -----
// Channel   Direction  Beat contents (lowest bits first)
// s_axis    in         box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
// m_axis    out        hit, t_enter, t_exit
// cfg       in         cfg_index selects the ray register, cfg_data carries its value
//
// One box per cycle sustained while m_tready is high; the chain is three axis cells of four
// stages each (difference, multiply, scale/saturate, interval) plus the output register.
// Synchronous active-low reset empties every stage and loads the default ray.
// When m_tready is low the output register holds its beat; the chain keeps
// taking boxes until every stage is full, then s_tready drops.
module ray_box_slab_test
    import rbst_pkg::*;
#(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z, zero pad
    input  logic [((6*COORD_BITS+7)/8)*8-1:0] s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // hit, t_enter, t_exit, zero pad
    output logic [((2*COORD_BITS+8)/8)*8-1:0] m_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [COORD_BITS-1:0]  cfg_data
);

    localparam int W      = COORD_BITS;
    localparam int IN_TW  = ((6 * W + 7) / 8) * 8;
    localparam int OUT_TW = ((2 * W + 8) / 8) * 8;

    // ray registers
    logic [NUM_AXES-1:0][W-1:0] origin_reg, inv_dir_reg;
    logic [W-2:0]               clip_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                origin_reg[k]  <= '0;
                inv_dir_reg[k] <= W'(1) << FRAC_BITS;
            end
            clip_reg <= '1;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_ORIGIN_X:  origin_reg[0]  <= cfg_data;
                REG_ORIGIN_Y:  origin_reg[1]  <= cfg_data;
                REG_ORIGIN_Z:  origin_reg[2]  <= cfg_data;
                REG_INV_DIR_X: inv_dir_reg[0] <= cfg_data;
                REG_INV_DIR_Y: inv_dir_reg[1] <= cfg_data;
                REG_INV_DIR_Z: inv_dir_reg[2] <= cfg_data;
                REG_CLIP_DIST: clip_reg       <= cfg_data[W-2:0];
                default: ;
            endcase
        end
    end

    // links between cells; link 0 is the input, link NUM_AXES the last cell
    logic [NUM_AXES:0]                       lk_valid, lk_ready, lk_miss;
    logic [NUM_AXES:0][NUM_AXES-1:0][W-1:0]  lk_bmin, lk_bmax;
    logic [NUM_AXES:0][W-1:0]                lk_tmin, lk_tmax;

    assign lk_valid[0] = s_tvalid;
    assign s_tready    = lk_ready[0];
    assign lk_tmin[0]  = '0;
    assign lk_tmax[0]  = {1'b0, clip_reg};
    assign lk_miss[0]  = 1'b0;

    for (genvar k = 0; k < NUM_AXES; k++) begin : g_unpack
        assign lk_bmin[0][k] = s_tdata[k*W +: W];
        assign lk_bmax[0][k] = s_tdata[(NUM_AXES+k)*W +: W];
    end

    for (genvar k = 0; k < NUM_AXES; k++) begin : g_cell
        rbst_axis_cell #(
            .W    (W),
            .F    (FRAC_BITS),
            .AXIS (k)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .org         (origin_reg[k]),
            .inv         (inv_dir_reg[k]),
            .in_valid    (lk_valid[k]),
            .in_ready    (lk_ready[k]),
            .in_box_min  (lk_bmin[k]),
            .in_box_max  (lk_bmax[k]),
            .in_tmin     (lk_tmin[k]),
            .in_tmax     (lk_tmax[k]),
            .in_miss     (lk_miss[k]),
            .out_valid   (lk_valid[k+1]),
            .out_ready   (lk_ready[k+1]),
            .out_box_min (lk_bmin[k+1]),
            .out_box_max (lk_bmax[k+1]),
            .out_tmin    (lk_tmin[k+1]),
            .out_tmax    (lk_tmax[k+1]),
            .out_miss    (lk_miss[k+1])
        );
    end

    // output register; zero the interval on a miss
    logic              m_valid_reg;
    logic [OUT_TW-1:0] m_data_reg, m_data_next;

    assign lk_ready[NUM_AXES] = !m_valid_reg || m_tready;

    always_comb begin
        m_data_next = '0;
        if (!lk_miss[NUM_AXES]) begin
            m_data_next[0]         = 1'b1;
            m_data_next[1 +: W]    = lk_tmin[NUM_AXES];
            m_data_next[1+W +: W]  = lk_tmax[NUM_AXES];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (lk_ready[NUM_AXES]) begin
            m_valid_reg <= lk_valid[NUM_AXES];
        end
    end

    always_ff @(posedge aclk) begin
        if (lk_ready[NUM_AXES] && lk_valid[NUM_AXES]) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // padding bits above the box fields and the corners leaving the last cell carry nothing
    logic unused_pad;
    assign unused_pad = ^{s_tdata[IN_TW-1:0], lk_bmin[NUM_AXES], lk_bmax[NUM_AXES]};

endmodule

// ----- verif/ray_box_slab_check.sv -----
module ray_box_slab_check
    import rbst_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    input  logic                    s_tready,
    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
    input  logic [191:0]            s_tdata,
    input  logic                    m_tvalid,
    input  logic                    m_tready,
    // hit, t_enter, t_exit, zero pad
    input  logic [71:0]             m_tdata,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [31:0]             cfg_data,
    output int                      mismatches,
    output int                      outstanding
);

    localparam logic signed [31:0] Q16_ONE = 32'sh0001_0000;

    typedef logic signed [31:0] q16_t;
    typedef logic [5:0][31:0] box_t;
    typedef struct packed {
        q16_t t_exit;
        q16_t t_enter;
        logic hit;
    } slab_hit_t;

    q16_t        ray_origin  [NUM_AXES];
    q16_t        ray_inv_dir [NUM_AXES];
    logic [30:0] ray_clip;
    slab_hit_t   expected_hits [$];

    // (coord - org) * inv, scaled down with truncation toward zero, then saturated
    function automatic q16_t scaled_offset(q16_t coord, q16_t org, q16_t inv);
        logic signed [32:0] diff;
        logic [32:0]        diff_mag;
        logic [31:0]        inv_mag;
        logic [63:0]        prod;
        logic [47:0]        quo;
        logic [31:0]        lim;
        logic [31:0]        mag;
        logic               neg;
        diff     = $signed({coord[31], coord}) - $signed({org[31], org});
        neg      = diff[32] ^ inv[31];
        diff_mag = diff[32] ? -diff : diff;
        inv_mag  = inv[31] ? -inv : inv;
        prod     = 64'(diff_mag) * 64'(inv_mag);
        quo      = prod[63:16];
        lim      = neg ? 32'h8000_0000 : 32'h7fff_ffff;
        if (quo > 48'(lim)) begin
            quo = 48'(lim);
        end
        mag = quo[31:0];
        return neg ? -mag : mag;
    endfunction

    function automatic slab_hit_t slab_intersect(box_t box);
        q16_t      t_lo;
        q16_t      t_hi;
        q16_t      t_near;
        q16_t      t_far;
        q16_t      swap;
        slab_hit_t res;
        t_lo = '0;
        t_hi = q16_t'({1'b0, ray_clip});
        for (int ax = 0; ax < NUM_AXES; ax++) begin
            t_near = scaled_offset(box[ax], ray_origin[ax], ray_inv_dir[ax]);
            t_far  = scaled_offset(box[ax+3], ray_origin[ax], ray_inv_dir[ax]);
            if (t_near > t_far) begin
                swap   = t_near;
                t_near = t_far;
                t_far  = swap;
            end
            if (t_near > t_lo) t_lo = t_near;
            if (t_far < t_hi) t_hi = t_far;
            // empty interval: miss, all fields zero
            if (t_lo > t_hi) return '0;
        end
        res.hit     = 1'b1;
        res.t_enter = t_lo;
        res.t_exit  = t_hi;
        return res;
    endfunction

    always @(posedge aclk) begin
        slab_hit_t got;
        slab_hit_t want;
        if (!aresetn) begin
            for (int ax = 0; ax < NUM_AXES; ax++) begin
                ray_origin[ax]  = '0;
                ray_inv_dir[ax] = Q16_ONE;
            end
            ray_clip = '1;
            expected_hits.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_ORIGIN_X:  ray_origin[0]  = cfg_data;
                    REG_ORIGIN_Y:  ray_origin[1]  = cfg_data;
                    REG_ORIGIN_Z:  ray_origin[2]  = cfg_data;
                    REG_INV_DIR_X: ray_inv_dir[0] = cfg_data;
                    REG_INV_DIR_Y: ray_inv_dir[1] = cfg_data;
                    REG_INV_DIR_Z: ray_inv_dir[2] = cfg_data;
                    REG_CLIP_DIST: ray_clip       = cfg_data[30:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                expected_hits.push_back(slab_intersect(s_tdata));
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[64:0];
                if (expected_hits.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: result beat with none expected: hit %0d enter %h exit %h",
                                 $time, got.hit, got.t_enter, got.t_exit);
                    end
                end else begin
                    want = expected_hits.pop_front();
                    if (got.hit !== want.hit || got.t_enter !== want.t_enter
                            || got.t_exit !== want.t_exit) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: hit %0d/%0d enter %h/%h exit %h/%h (expected/actual)",
                                     $time, want.hit, got.hit, want.t_enter, got.t_enter,
                                     want.t_exit, got.t_exit);
                        end
                    end
                end
            end
        end
        outstanding = expected_hits.size();
    end

endmodule

// ----- verif/tb.sv -----
module tb;
    import rbst_pkg::*;

    localparam int COORD_BITS    = 32;
    localparam int FRAC_BITS     = 16;
    localparam int BOX_W         = ((6*COORD_BITS+7)/8)*8;
    localparam int HIT_W         = ((2*COORD_BITS+8)/8)*8;
    localparam int RAYS          = 8;
    localparam int BOXES_PER_RAY = 175;
    localparam int DRAIN_CYCLES  = 40;

    localparam logic [CFG_IDX_BITS-1:0] REG_UNMAPPED = 3'd7;

    typedef logic signed [31:0] q16_t;
    typedef logic [5:0][31:0] box_t;

    localparam q16_t Q16_ONE = 32'sh0001_0000;
    localparam q16_t Q16_MIN = 32'sh8000_0000;
    localparam q16_t Q16_MAX = 32'sh7fff_ffff;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [BOX_W-1:0]        s_tdata;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [HIT_W-1:0]        m_tdata;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [31:0]             cfg_data;
    int                      mismatches;
    int                      outstanding;
    bit                      calm;
    q16_t                    aim [NUM_AXES];

    ray_box_slab_test #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ray_box_slab_check i_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #200000;
        $display("CHECKS FAILED");
        $finish;
    end

    // result side back-pressure
    initial begin
        m_tready = 1'b1;
        forever begin
            @(posedge aclk);
            m_tready <= calm || $urandom_range(0, 99) >= 9;
        end
    end

    function automatic box_t corners(q16_t x0, q16_t y0, q16_t z0,
                                     q16_t x1, q16_t y1, q16_t z1);
        return {z1, y1, x1, z0, y0, x0};
    endfunction

    function automatic q16_t jitter(int span);
        return $signed($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic q16_t edge_value(q16_t around);
        case ($urandom_range(0, 4))
            0:       return Q16_MIN;
            1:       return Q16_MAX;
            2:       return '0;
            3:       return around;
            default: return $urandom;
        endcase
    endfunction

    function automatic box_t random_box();
        box_t b;
        q16_t c;
        q16_t half;
        int   kind;
        kind = $urandom_range(0, 99);
        for (int ax = 0; ax < NUM_AXES; ax++) begin
            if (kind < 70) begin
                // box placed near the ray origin so that hits are common
                c    = aim[ax] + jitter(1 << 20);
                half = $urandom_range(0, 1 << 19);
                if ($urandom_range(0, 4) == 0) begin
                    b[ax]   = c + half;
                    b[ax+3] = c - half;
                end else begin
                    b[ax]   = c - half;
                    b[ax+3] = c + half;
                end
            end else if (kind < 85) begin
                b[ax]   = $urandom;
                b[ax+3] = $urandom;
            end else begin
                b[ax]   = edge_value(aim[ax]);
                b[ax+3] = edge_value(aim[ax]);
            end
        end
        return b;
    endfunction

    task automatic send_box(input box_t b);
        while (!calm && $urandom_range(0, 99) < 9) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
    endtask

    // drop valid and wait for every outstanding result
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(negedge aclk);
        @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(negedge aclk); while (!cfg_ready);
        @(posedge aclk);
    endtask

    task automatic load_ray(input q16_t ox, input q16_t oy, input q16_t oz,
                            input q16_t ix, input q16_t iy, input q16_t iz,
                            input logic [31:0] clip);
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_ORIGIN_Z, oz);
        write_reg(REG_INV_DIR_X, ix);
        write_reg(REG_INV_DIR_Y, iy);
        write_reg(REG_INV_DIR_Z, iz);
        write_reg(REG_CLIP_DIST, clip);
        // unmapped index must leave the ray alone
        write_reg(REG_UNMAPPED, $urandom);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        aim[0] = ox;
        aim[1] = oy;
        aim[2] = oz;
    endtask

    function automatic q16_t random_origin();
        return ($urandom_range(0, 1) == 0) ? jitter(1 << 22) : q16_t'($urandom);
    endfunction

    function automatic q16_t random_inv_dir();
        return ($urandom_range(0, 3) != 0) ? jitter(1 << 20) : q16_t'($urandom);
    endfunction

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        calm      = 1'b0;
        aim[0]    = '0;
        aim[1]    = '0;
        aim[2]    = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int ray = 0; ray < RAYS; ray++) begin
            calm = (ray == 4);
            case (ray)
                0: begin
                    // default ray: unit direction from the origin, widest clip
                    send_box(corners(Q16_ONE, Q16_ONE, Q16_ONE,
                                     2 * Q16_ONE, 2 * Q16_ONE, 2 * Q16_ONE));
                    send_box(corners(-Q16_ONE, -Q16_ONE, -Q16_ONE, Q16_ONE, Q16_ONE, Q16_ONE));
                    send_box(corners(-3 * Q16_ONE, -3 * Q16_ONE, -3 * Q16_ONE,
                                     -2 * Q16_ONE, -2 * Q16_ONE, -2 * Q16_ONE));
                    send_box(corners(2 * Q16_ONE, 2 * Q16_ONE, 2 * Q16_ONE,
                                     Q16_ONE, Q16_ONE, Q16_ONE));
                    send_box(corners(3 * Q16_ONE, '0, '0, 3 * Q16_ONE, 5 * Q16_ONE, 5 * Q16_ONE));
                    send_box(corners(Q16_ONE, 3 * Q16_ONE, '0,
                                     2 * Q16_ONE, 4 * Q16_ONE, 5 * Q16_ONE));
                    send_box(corners(Q16_MIN, Q16_MIN, Q16_MIN, Q16_MAX, Q16_MAX, Q16_MAX));
                    send_box(corners(Q16_MIN, Q16_MIN, Q16_MIN, Q16_MIN, Q16_MIN, Q16_MIN));
                    send_box(corners(Q16_MAX, Q16_MAX, Q16_MAX, Q16_MAX, Q16_MAX, Q16_MAX));
                    send_box('0);
                end
                1: begin
                    // zero direction on x and y: saturated reciprocals, zero clip
                    load_ray(3 * Q16_ONE / 2, -2 * Q16_ONE, '0, Q16_MAX, Q16_MIN, Q16_ONE, '0);
                    send_box(corners(Q16_ONE, -3 * Q16_ONE, -Q16_ONE,
                                     2 * Q16_ONE, -Q16_ONE, Q16_ONE));
                    send_box(corners(3 * Q16_ONE / 2, -3 * Q16_ONE, -Q16_ONE,
                                     3 * Q16_ONE / 2, -Q16_ONE, Q16_ONE));
                    send_box(corners(2 * Q16_ONE, -3 * Q16_ONE, -Q16_ONE,
                                     3 * Q16_ONE, -Q16_ONE, Q16_ONE));
                    send_box(corners(Q16_MIN, Q16_MIN, Q16_MIN, Q16_MAX, Q16_MAX, Q16_MAX));
                end
                RAYS - 1: begin
                    load_ray(Q16_MIN, Q16_MAX, '0, Q16_MIN, Q16_MAX, -Q16_ONE, 32'hffff_ffff);
                    send_box(corners(Q16_MIN, Q16_MIN, Q16_MIN, Q16_MIN, Q16_MIN, Q16_MIN));
                    send_box(corners(Q16_MAX, Q16_MAX, Q16_MAX, Q16_MAX, Q16_MAX, Q16_MAX));
                    send_box(corners(Q16_MIN, Q16_MIN, Q16_MIN, Q16_MAX, Q16_MAX, Q16_MAX));
                end
                default: begin
                    load_ray(random_origin(), random_origin(), random_origin(),
                             random_inv_dir(), random_inv_dir(), random_inv_dir(),
                             ($urandom_range(0, 1) == 0) ? $urandom
                                                         : $urandom_range(0, 1 << 22));
                end
            endcase
            for (int n = 0; n < BOXES_PER_RAY; n++) begin
                send_box(random_box());
            end
            settle();
        end

        calm = 1'b0;
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- ray_box_slab_test.f -----
rtl/core/rbst_pkg.sv
rtl/core/rbst_axis_cell.sv
rtl/core/ray_box_slab_test.sv
verif/ray_box_slab_check.sv
verif/tb.sv
